### rtl/pirl_pkg.sv
// Shared types and constants for the positional insert/remove list.
package pirl_pkg;

    localparam int unsigned FUNC_W  = 1;
    localparam int unsigned POS_W   = 8;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned ECNT_W  = 8;

    // s_tdata: func, position, value packed from bit 0, padded to bytes
    localparam int unsigned S_RAW_W  = FUNC_W + POS_W + VALUE_W;
    localparam int unsigned S_DATA_W = ((S_RAW_W + 7) / 8) * 8;
    // m_tdata: removed_value, status, entry_count packed from bit 0
    localparam int unsigned M_RAW_W  = VALUE_W + STAT_W + ECNT_W;
    localparam int unsigned M_DATA_W = ((M_RAW_W + 7) / 8) * 8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 1'b0,
        FUNC_REMOVE = 1'b1
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_EMPTY  = 2'd2,
        STAT_BADPOS = 2'd3
    } status_t;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic               shift_up;    // insert: cells above pos take left neighbor
        logic               shift_down;  // remove: cells at/above pos take right neighbor
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] value;
    } cell_ctrl_t;

endpackage : pirl_pkg

### rtl/pirl_cell.sv
// One list slot: holds an entry and trades it with its neighbors on a shift.
module pirl_cell
    import pirl_pkg::*;
#(
    parameter int unsigned INDEX = 0
) (
    input  logic               aclk,
    input  cell_ctrl_t         ctrl_i,
    input  logic [VALUE_W-1:0] left_i,   // entry of the cell below
    input  logic [VALUE_W-1:0] right_i,  // entry of the cell above
    output logic [VALUE_W-1:0] data_o
);

    localparam logic [31:0] IDX = 32'(INDEX);

    logic [VALUE_W-1:0] data_reg;
    logic [VALUE_W-1:0] data_next;
    logic [31:0]        pos_ext;

    assign pos_ext = 32'(ctrl_i.pos);

    always_comb begin
        data_next = data_reg;
        priority if (ctrl_i.shift_up) begin
            if (IDX > pos_ext) begin
                data_next = left_i;
            end else if (IDX == pos_ext) begin
                data_next = ctrl_i.value;
            end
        end else if (ctrl_i.shift_down) begin
            if (IDX >= pos_ext) begin
                data_next = right_i;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_o = data_reg;

endmodule : pirl_cell

### rtl/positional_insert_remove_list.sv
// An accepted item's result is registered and shows on m_tvalid/m_tdata in the next cycle.
// One item per cycle while m_tready keeps draining the output register; every cell
//   of the chain compares its index with the position and shifts in the same cycle the item is accepted.
// s_tready stays high while the output register is empty or being drained.
// Reset (aresetn low, synchronous) empties the list and the output register;
//   entry cells are not cleared, only slots below the count are ever read.
module positional_insert_remove_list
    import pirl_pkg::*;
#(
    parameter int unsigned DEPTH = 128
) (
    input  logic                aclk,
    input  logic                aresetn,
    // input items
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [0] func, [8:1] position, [40:9] value
    // result items
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // [31:0] removed_value, [33:32] status,
                                           // [41:34] entry_count
);

    // count needs to hold DEPTH itself
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    // common width for comparing position against count
    localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    // only the lowest 2**POS_W cells can be addressed for a read
    localparam int unsigned RD_N  = (DEPTH < (1 << POS_W)) ? DEPTH : (1 << POS_W);
    localparam int unsigned RD_W  = $clog2(RD_N);

    // ---------------- input unpack ----------------
    func_t              in_func;
    logic [POS_W-1:0]   in_pos;
    logic [VALUE_W-1:0] in_value;

    assign in_func  = func_t'(s_tdata[FUNC_W-1:0]);
    assign in_pos   = s_tdata[FUNC_W +: POS_W];
    assign in_value = s_tdata[FUNC_W+POS_W +: VALUE_W];

    // ---------------- state ----------------
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                m_valid_reg;
    logic                m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg;
    logic [M_DATA_W-1:0] m_data_next;

    logic               accept;
    status_t            status;
    logic [CMP_W-1:0]   pos_cmp;
    logic [CMP_W-1:0]   cnt_cmp;
    logic [VALUE_W-1:0] removed;
    cell_ctrl_t         ctrl;
    logic [VALUE_W-1:0] cell_data [DEPTH];
    logic [RD_W-1:0]    rd_idx;
    logic [CMP_W-1:0]   cnt_out;

    // output register frees up when it is empty or being taken this cycle
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign pos_cmp = CMP_W'(in_pos);
    assign cnt_cmp = CMP_W'(count_reg);

    // Error checks: full/empty take precedence over a bad position.
    always_comb begin
        unique case (in_func)
            FUNC_INSERT: begin
                priority if (count_reg == CNT_W'(DEPTH)) begin
                    status = STAT_FULL;
                end else if (pos_cmp > cnt_cmp) begin
                    status = STAT_BADPOS;
                end else begin
                    status = STAT_OK;
                end
            end
            FUNC_REMOVE: begin
                priority if (count_reg == '0) begin
                    status = STAT_EMPTY;
                end else if (pos_cmp >= cnt_cmp) begin
                    status = STAT_BADPOS;
                end else begin
                    status = STAT_OK;
                end
            end
            default: status = STAT_BADPOS;
        endcase
    end

    // Broadcast to the chain; only a successful, accepted item moves entries.
    always_comb begin
        ctrl.shift_up   = accept && (status == STAT_OK) && (in_func == FUNC_INSERT);
        ctrl.shift_down = accept && (status == STAT_OK) && (in_func == FUNC_REMOVE);
        ctrl.pos        = in_pos;
        ctrl.value      = in_value;
    end

    // ---------------- cell chain ----------------
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic [VALUE_W-1:0] left_w;
        logic [VALUE_W-1:0] right_w;

        if (gi == 0) begin : g_first
            assign left_w = in_value;          // never selected at index 0
        end else begin : g_mid_lo
            assign left_w = cell_data[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_last
            assign right_w = cell_data[gi];    // top slot keeps its stale entry
        end else begin : g_mid_hi
            assign right_w = cell_data[gi+1];
        end

        pirl_cell #(
            .INDEX (gi)
        ) u_cell (
            .aclk   (aclk),
            .ctrl_i (ctrl),
            .left_i (left_w),
            .right_i(right_w),
            .data_o (cell_data[gi])
        );
    end

    // Removed value read from the addressed cell before the chain shifts.
    // A successful remove has pos < count <= DEPTH, so the index is in range.
    assign rd_idx  = in_pos[RD_W-1:0];
    assign removed = ctrl.shift_down ? cell_data[rd_idx] : '0;

    // ---------------- count and output register ----------------
    always_comb begin
        count_next = count_reg;
        if (ctrl.shift_up) begin
            count_next = count_reg + CNT_W'(1);
        end else if (ctrl.shift_down) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign cnt_out = CMP_W'(count_next);

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (accept) begin
            m_valid_next = 1'b1;
            m_data_next  = M_DATA_W'({cnt_out[ECNT_W-1:0], status, removed});
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef ASSERT_OFF
    // list never grows past its capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("list count above DEPTH");

    // failed operations report no removed value
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[VALUE_W +: STAT_W] != STAT_OK))
            |-> (m_tdata[VALUE_W-1:0] == '0))
        else $error("nonzero removed value on error status");

    // a successful insert grows the count by exactly one
    a_ins_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.shift_up |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not advance count");

    // an accepted item always shows up in the output register next cycle
    a_accept_out: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_tvalid)
        else $error("accepted item produced no result");
`endif

endmodule : positional_insert_remove_list
